FILE: design/sns_pkg.sv
package sns_pkg;

    localparam int SIZE_W    = 10;   // frame_width / frame_height register width
    localparam int COORD_W   = 9;    // read_x / read_y
    localparam int SAMPLE_W  = 16;
    localparam int PIXEL_W   = 8;
    localparam int GRID_STEP = 100;
    localparam int WHITE     = 255;
    localparam int MIN_SIZE  = 2;
    localparam int SIZE_TOP  = 1022; // largest even value of a 10-bit size register

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = 2;
    localparam int Q_CW    = 3;

    localparam int DIV_STEPS = 8;
    localparam int DIV_W     = SAMPLE_W + PIXEL_W;

    typedef enum logic [1:0]
    {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_GRID_ENABLE  = 2'd2
    } cfg_index_t;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                   op;
        logic [SAMPLE_W-1:0]   sample;
        logic                  in_range;
        logic                  grid_hit;
        logic [SIZE_W-1:0]     xs;
        logic [SIZE_W-1:0]     ys;
    } entry_t;

    typedef struct packed
    {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } geom_t;

    typedef struct packed
    {
        logic            empty;
        logic            full;
        logic [Q_CW-1:0] count;
    } q_stat_t;

    typedef struct packed
    {
        logic idle;
        logic result_pending;
    } bk_stat_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_ADDR,
        BK_MEM,
        BK_EVAL,
        BK_DIV,
        BK_DONE
    } bk_state_t;

    function automatic logic [6:0] mod_grid(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = v;
        if (r >= COORD_W'(GRID_STEP * 4))
            r = r - COORD_W'(GRID_STEP * 4);
        if (r >= COORD_W'(GRID_STEP * 2))
            r = r - COORD_W'(GRID_STEP * 2);
        if (r >= COORD_W'(GRID_STEP))
            r = r - COORD_W'(GRID_STEP);
        return r[6:0];
    endfunction

endpackage

FILE: design/sns_front.sv
module sns_front import sns_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [SIZE_W-1:0]  cfg_wdata,
    input  logic               in_tvalid,
    output logic               in_tready,
    input  logic [39:0]        in_tdata,
    input  logic               in_tuser,
    input  logic               q_full,
    output logic               q_push,
    output entry_t             q_entry,
    output geom_t              geom
);

    localparam int EVEN_MAX_W = MAX_WIDTH / 2 * 2;
    localparam int EVEN_MAX_H = MAX_HEIGHT / 2 * 2;
    localparam int TOP_W = (EVEN_MAX_W > SIZE_TOP) ? SIZE_TOP : EVEN_MAX_W;
    localparam int TOP_H = (EVEN_MAX_H > SIZE_TOP) ? SIZE_TOP : EVEN_MAX_H;

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic               grid_reg;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [COORD_W-1:0] hw;
    logic [COORD_W-1:0] hh;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               in_range;
    logic               grid_hit;
    logic [SIZE_W-1:0]  xs;
    logic [SIZE_W-1:0]  ys;

    function automatic logic [SIZE_W-1:0] even_size(input logic [SIZE_W-1:0] r,
                                                    input logic [SIZE_W-1:0] top);
        logic [SIZE_W-1:0] v;
        v = {r[SIZE_W-1:1], 1'b0};
        if (v < SIZE_W'(MIN_SIZE))
            v = SIZE_W'(MIN_SIZE);
        if (v > top)
            v = top;
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(512);
            height_reg <= SIZE_W'(512);
            grid_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                CFG_GRID_ENABLE:  grid_reg   <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    assign w  = even_size(width_reg, SIZE_W'(TOP_W));
    assign h  = even_size(height_reg, SIZE_W'(TOP_H));
    assign hw = w[SIZE_W-1:1];
    assign hh = h[SIZE_W-1:1];
    assign geom.w = w;
    assign geom.h = h;

    assign x = in_tdata[24:16];
    assign y = in_tdata[33:25];

    always_comb
    begin
        in_range = ({1'b0, x} < w) && ({1'b0, y} < h);
        // quadrant swap: move each half of the axis by half the size
        if (x < hw)
            xs = {1'b0, x} + {1'b0, hw};
        else
            xs = {1'b0, x} - {1'b0, hw};
        if (y < hh)
            ys = {1'b0, y} + {1'b0, hh};
        else
            ys = {1'b0, y} - {1'b0, hh};
        if (!in_range)
        begin
            xs = '0;
            ys = '0;
        end
        grid_hit = grid_reg && ((mod_grid(x) == mod_grid(hw)) || (mod_grid(y) == mod_grid(hh)));
    end

    assign in_tready = !q_full;
    assign q_push    = in_tvalid && !q_full;

    assign q_entry.op       = op_t'(in_tuser);
    assign q_entry.sample   = in_tdata[15:0];
    assign q_entry.in_range = in_range;
    assign q_entry.grid_hit = grid_hit;
    assign q_entry.xs       = xs;
    assign q_entry.ys       = ys;

endmodule

FILE: design/sns_queue.sv
module sns_queue import sns_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t stat
);

    entry_t          slot_reg [Q_DEPTH];
    logic [Q_PW-1:0] wr_ptr_reg;
    logic [Q_PW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign stat.count = count_reg;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: design/sns_back.sv
module sns_back import sns_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  geom_t              geom,
    input  entry_t             head,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               out_tvalid,
    input  logic               out_tready,
    output logic [PIXEL_W-1:0] out_pixel,
    output logic               out_frame_ready,
    output bk_stat_t           stat
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 2 * SIZE_W + 1;
    localparam int CW    = ((AW > PW) ? AW : PW) + 1;

    bk_state_t            state_reg;
    bk_state_t            state_next;

    logic [SAMPLE_W-1:0]  mem [DEPTH];
    logic [SAMPLE_W-1:0]  rd_data_reg;
    entry_t               entry_reg;
    logic [AW-1:0]        addr_reg;
    logic [SAMPLE_W-1:0]  peak_reg;
    logic [AW-1:0]        load_index_reg;
    logic                 loaded_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [PIXEL_W-1:0]   quo_reg;
    logic [2:0]           cnt_reg;
    logic [PIXEL_W-1:0]   pix_reg;
    logic                 out_valid_reg;
    logic [PIXEL_W-1:0]   out_pixel_reg;
    logic                 out_ready_flag_reg;

    logic                 do_load;
    logic                 latch_read;
    logic                 mem_rd;
    logic                 set_pix;
    logic [PIXEL_W-1:0]   pix_value;
    logic                 div_start;
    logic                 div_step;
    logic                 emit;

    logic [2*SIZE_W-1:0]  total;
    logic [PW-1:0]        addr_full;
    logic                 last_load;
    logic [SAMPLE_W:0]    two_s;
    logic [DIV_W-1:0]     prod;
    logic [DIV_W-1:0]     peak_sh8;
    logic                 div_ge;
    logic [DIV_W-1:0]     rem_sub;

    assign total     = geom.w * geom.h;
    assign last_load = (CW'(load_index_reg) + CW'(1)) >= CW'(total);
    assign addr_full = PW'({{SIZE_W{1'b0}}, entry_reg.ys} * geom.w) + PW'(entry_reg.xs);

    assign two_s    = {rd_data_reg, 1'b0};
    assign prod     = {rd_data_reg, 8'b0} - DIV_W'(rd_data_reg);   // 255 * sample
    assign peak_sh8 = {peak_reg, 8'b0};
    assign div_ge   = rem_reg >= dvs_reg;
    assign rem_sub  = rem_reg - dvs_reg;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        do_load    = 1'b0;
        latch_read = 1'b0;
        mem_rd     = 1'b0;
        set_pix    = 1'b0;
        pix_value  = '0;
        div_start  = 1'b0;
        div_step   = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (head.op == OP_READ)
                    begin
                        latch_read = 1'b1;
                        state_next = BK_ADDR;
                    end
                    else
                    begin
                        do_load = 1'b1;
                    end
                end
            end
            BK_ADDR:
            begin
                state_next = BK_MEM;
            end
            BK_MEM:
            begin
                mem_rd     = 1'b1;
                state_next = BK_EVAL;
            end
            BK_EVAL:
            begin
                state_next = BK_DONE;
                set_pix    = 1'b1;
                if (!entry_reg.in_range)
                    pix_value = '0;
                else if (entry_reg.grid_hit)
                    pix_value = PIXEL_W'(WHITE);
                else if (two_s <= {1'b0, peak_reg})
                    pix_value = '0;
                else if (peak_reg == '0 || prod >= peak_sh8)
                    pix_value = PIXEL_W'(WHITE);
                else
                begin
                    set_pix    = 1'b0;
                    div_start  = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    set_pix    = 1'b1;
                    pix_value  = {quo_reg[PIXEL_W-2:0], div_ge};
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_tready)
                begin
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // frame store: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_load)
            mem[load_index_reg] <= head.sample;
        if (mem_rd)
            rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg       <= '0;
            load_index_reg <= '0;
            loaded_reg     <= 1'b0;
        end
        else if (do_load)
        begin
            if (load_index_reg == '0)
            begin
                peak_reg   <= '0;
                loaded_reg <= 1'b0;
            end
            else if (head.sample > peak_reg)
            begin
                peak_reg <= head.sample;
            end
            if (last_load)
            begin
                load_index_reg <= '0;
                loaded_reg     <= 1'b1;
            end
            else
            begin
                load_index_reg <= load_index_reg + 1'b1;
            end
        end
    end

    // read path payload; restoring divide, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (latch_read)
            entry_reg <= head;
        if (state_reg == BK_ADDR)
            addr_reg <= AW'(addr_full);
        if (div_start)
        begin
            rem_reg <= prod;
            dvs_reg <= {1'b0, peak_reg, 7'b0};
            quo_reg <= '0;
            cnt_reg <= 3'(DIV_STEPS - 1);
        end
        else if (div_step)
        begin
            if (div_ge)
                rem_reg <= rem_sub;
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[PIXEL_W-2:0], div_ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (set_pix)
            pix_reg <= pix_value;
        if (emit)
        begin
            out_pixel_reg      <= pix_reg;
            out_ready_flag_reg <= loaded_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_tready)
            out_valid_reg <= 1'b0;
    end

    assign out_tvalid          = out_valid_reg;
    assign out_pixel           = out_pixel_reg;
    assign out_frame_ready     = out_ready_flag_reg;
    assign stat.idle           = (state_reg == BK_IDLE);
    assign stat.result_pending = (state_reg == BK_DONE);

endmodule

FILE: design/spectrum_normalize_shift.sv
// Spectrum display store and normalizer. Load items (tuser = 0) write one
// Q5.11 log-magnitude sample each, in raster order, into a frame store of
// MAX_WIDTH x MAX_HEIGHT words and track the peak over all samples but the
// first. Read items (tuser = 1) return one gray pixel of the quadrant-swapped
// image, scaled so the peak maps to 255, with samples at or below half the
// peak shown black and an optional white grid every 100 pixels. Items pass
// through a four-entry queue into the back end, which handles them in order.
// A load is handled in the idle state, which stays ready for the next item.
// A read goes through address multiply and frame store read; unless the
// answer is settled without a divide (outside the frame, grid line, black,
// or white), the quotient is then formed one bit per cycle. The frame store
// has no reset; reading a location never loaded since reset returns an
// undefined pixel. Configuration writes take effect at once and are meant
// to be made while no item is in flight.
module spectrum_normalize_shift import sns_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // sample[15:0], read_x[24:16], read_y[33:25]
    input  logic              s_axis_tuser,   // operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata    // pixel[7:0], frame_ready[8]
);

    geom_t              geom;
    entry_t             push_entry;
    entry_t             head;
    logic               q_push;
    logic               q_pop;
    q_stat_t            q_stat;
    bk_stat_t           bk_stat;
    logic [PIXEL_W-1:0] pixel;
    logic               frame_ready;

    sns_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .q_full    (q_stat.full),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .geom      (geom)
    );

    sns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .stat       (q_stat)
    );

    sns_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .geom            (geom),
        .head            (head),
        .q_empty         (q_stat.empty),
        .q_pop           (q_pop),
        .out_tvalid      (m_axis_tvalid),
        .out_tready      (m_axis_tready),
        .out_pixel       (pixel),
        .out_frame_ready (frame_ready),
        .stat            (bk_stat)
    );

    assign m_axis_tdata = {7'b0, frame_ready, pixel};

    // nothing queued and back end idle: no result can appear next cycle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.empty && bk_stat.idle && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared with no item in flight");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(bk_stat.result_pending))
        else $error("output valid rose without a finished read");

    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !q_pop) |=>
            (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("accepted item not held in queue");

endmodule
